@@ hw/rtl/stra_pkg.sv @@
// ----------------------------------------------------------------------------
// stra_pkg
// Shared constants, types and the arctangent table for the spindle angle unit.
// ----------------------------------------------------------------------------
package stra_pkg;

  localparam int COMPONENT_WIDTH_DEF = 16;
  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int ATAN_TABLE_LEN      = 24;

  // Components are scaled up by this many bits before the CORDIC passes
  localparam int GUARD_BITS  = 12;
  // Headroom for quadrant fold, CORDIC gain and the second pass
  localparam int HEADROOM    = 4;

  // Angle accumulator: degrees with 16 fraction bits
  localparam int ANGLE_ACC_W = 26;
  localparam int ANGLE_W     = 17;
  localparam int LIMIT_W     = 16;
  localparam int ROUND_SHIFT = 8;

  localparam logic signed [ANGLE_W-1:0]     ANGLE_MAX    = 17'sd46080;
  localparam logic signed [ANGLE_ACC_W-1:0] ANGLE_90_ACC = 26'sd5898240;

  // CORDIC gain K in Q16, applied to y ahead of the second pass
  localparam int GAIN_W    = 18;
  localparam int GAIN_DROP = 16 - GUARD_BITS;
  localparam logic signed [GAIN_W-1:0] GAIN_Q16 = 18'sd107922;

  localparam logic [LIMIT_W-1:0] TILT_LIMIT_RST   = 16'd30720;
  localparam logic [LIMIT_W-1:0] ROTATE_LIMIT_RST = 16'd23040;

  // Register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILT_LIMIT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_LIMIT = 1'b1;

  typedef struct packed {
    logic zero;     // all three components zero
    logic xz_zero;  // x and z both zero
  } axis_flags_t;

  // round(atan(2^-i) * 180/pi * 65536)
  localparam logic [21:0] ATAN_TABLE [ATAN_TABLE_LEN] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
    22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
  };

  function automatic logic [ANGLE_ACC_W-1:0] atan_angle(input logic [4:0] idx);
    logic [ANGLE_ACC_W-1:0] res;
    res = '0;
    if (idx < 5'(ATAN_TABLE_LEN)) begin
      res = ANGLE_ACC_W'(ATAN_TABLE[idx]);
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/stra_prep.sv @@
// ----------------------------------------------------------------------------
// stra_prep
// Entry stage: scales the components, folds z < 0 into the right half-plane
// and applies the CORDIC gain to y for the second pass.
// ----------------------------------------------------------------------------
module stra_prep import stra_pkg::*; #(
  parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
  parameter int DATA_W          = COMPONENT_WIDTH_DEF + GUARD_BITS + HEADROOM
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  logic                              valid_i,
  input  logic signed [COMPONENT_WIDTH-1:0] axis_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0] axis_y_i,
  input  logic signed [COMPONENT_WIDTH-1:0] axis_z_i,
  output logic                              valid_o,
  output logic signed [DATA_W-1:0]          re_o,
  output logic signed [DATA_W-1:0]          im_o,
  output logic signed [ANGLE_ACC_W-1:0]     acc_o,
  output logic signed [DATA_W-1:0]          y_im_o,
  output axis_flags_t                       flags_o
);

  localparam int PROD_W = COMPONENT_WIDTH + GAIN_W;

  logic signed [DATA_W-1:0]      xe, ze;
  logic signed [DATA_W-1:0]      re_d, im_d, y_im_d;
  logic signed [ANGLE_ACC_W-1:0] acc_d;
  logic signed [PROD_W-1:0]      y_prod;
  axis_flags_t                   flags_d;

  logic                          valid_q;
  logic signed [DATA_W-1:0]      re_q, im_q, y_im_q;
  logic signed [ANGLE_ACC_W-1:0] acc_q;
  axis_flags_t                   flags_q;

  assign xe = DATA_W'(axis_x_i) <<< GUARD_BITS;
  assign ze = DATA_W'(axis_z_i) <<< GUARD_BITS;

  always_comb begin
    if (axis_z_i[COMPONENT_WIDTH-1]) begin
      if (!axis_x_i[COMPONENT_WIDTH-1]) begin
        re_d  = xe;
        im_d  = -ze;
        acc_d = ANGLE_90_ACC;
      end else begin
        re_d  = -xe;
        im_d  = ze;
        acc_d = -ANGLE_90_ACC;
      end
    end else begin
      re_d  = ze;
      im_d  = xe;
      acc_d = '0;
    end
  end

  // floor(y * K * 2^GUARD_BITS), with K taken from GAIN_Q16
  assign y_prod = PROD_W'(axis_y_i) * PROD_W'(GAIN_Q16);
  assign y_im_d = DATA_W'($signed(y_prod[PROD_W-1:GAIN_DROP]));

  assign flags_d.xz_zero = (axis_x_i == '0) && (axis_z_i == '0);
  assign flags_d.zero    = flags_d.xz_zero && (axis_y_i == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      re_q    <= re_d;
      im_q    <= im_d;
      acc_q   <= acc_d;
      y_im_q  <= y_im_d;
      flags_q <= flags_d;
    end
  end

  assign valid_o = valid_q;
  assign re_o    = re_q;
  assign im_o    = im_q;
  assign acc_o   = acc_q;
  assign y_im_o  = y_im_q;
  assign flags_o = flags_q;

endmodule

@@ hw/rtl/stra_cordic_step.sv @@
// ----------------------------------------------------------------------------
// stra_cordic_step
// One registered vectoring iteration: rotates towards im = 0 and updates the
// angle accumulator. Side data rides along unchanged.
// ----------------------------------------------------------------------------
module stra_cordic_step import stra_pkg::*; #(
  parameter int DATA_W = COMPONENT_WIDTH_DEF + GUARD_BITS + HEADROOM,
  parameter int SIDE_W = 1,
  parameter int STEP   = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  logic signed [DATA_W-1:0]      re_i,
  input  logic signed [DATA_W-1:0]      im_i,
  input  logic signed [ANGLE_ACC_W-1:0] acc_i,
  input  logic [SIDE_W-1:0]             side_i,
  output logic                          valid_o,
  output logic signed [DATA_W-1:0]      re_o,
  output logic signed [DATA_W-1:0]      im_o,
  output logic signed [ANGLE_ACC_W-1:0] acc_o,
  output logic [SIDE_W-1:0]             side_o
);

  localparam logic [4:0] STEP_IDX = 5'(STEP);
  localparam logic signed [ANGLE_ACC_W-1:0] STEP_ANGLE = atan_angle(STEP_IDX);

  logic signed [DATA_W-1:0]      re_sh, im_sh;
  logic signed [DATA_W-1:0]      re_d, im_d;
  logic signed [ANGLE_ACC_W-1:0] acc_d;

  logic                          valid_q;
  logic signed [DATA_W-1:0]      re_q, im_q;
  logic signed [ANGLE_ACC_W-1:0] acc_q;
  logic [SIDE_W-1:0]             side_q;

  assign re_sh = re_i >>> STEP;
  assign im_sh = im_i >>> STEP;

  always_comb begin
    if (!im_i[DATA_W-1]) begin
      re_d  = re_i + im_sh;
      im_d  = im_i - re_sh;
      acc_d = acc_i + STEP_ANGLE;
    end else begin
      re_d  = re_i - im_sh;
      im_d  = im_i + re_sh;
      acc_d = acc_i - STEP_ANGLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      re_q   <= re_d;
      im_q   <= im_d;
      acc_q  <= acc_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign re_o    = re_q;
  assign im_o    = im_q;
  assign acc_o   = acc_q;
  assign side_o  = side_q;

endmodule

@@ hw/rtl/stra_finish.sv @@
// ----------------------------------------------------------------------------
// stra_finish
// Output stage: rounds and saturates both angles, checks the limits and
// applies the zero-vector cases. Doubles as the output register.
// ----------------------------------------------------------------------------
module stra_finish import stra_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  logic signed [ANGLE_ACC_W-1:0] acc_rot_i,
  input  logic signed [ANGLE_ACC_W-1:0] acc_tilt_i,
  input  axis_flags_t                   flags_i,
  input  logic [LIMIT_W-1:0]            tilt_limit_i,
  input  logic [LIMIT_W-1:0]            rotate_limit_i,
  output logic                          valid_o,
  output logic signed [ANGLE_W-1:0]     tilt_angle_o,
  output logic signed [ANGLE_W-1:0]     rotate_angle_o,
  output logic                          within_limits_o,
  output logic                          zero_axis_o
);

  localparam int RND_W = ANGLE_ACC_W - ROUND_SHIFT;

  function automatic logic signed [ANGLE_W-1:0] round_sat(
    input logic signed [ANGLE_ACC_W-1:0] acc
  );
    logic signed [ANGLE_ACC_W-1:0] biased;
    logic signed [RND_W-1:0]       rnd;
    logic signed [ANGLE_W-1:0]     res;
    biased = acc + ANGLE_ACC_W'(1 << (ROUND_SHIFT - 1));
    rnd    = biased[ANGLE_ACC_W-1:ROUND_SHIFT];
    if (rnd > RND_W'(ANGLE_MAX)) begin
      res = ANGLE_MAX;
    end else if (rnd < -RND_W'(ANGLE_MAX)) begin
      res = -ANGLE_MAX;
    end else begin
      res = rnd[ANGLE_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [LIMIT_W-1:0] mag(input logic signed [ANGLE_W-1:0] v);
    logic signed [ANGLE_W-1:0] a;
    a = v[ANGLE_W-1] ? -v : v;
    return a[LIMIT_W-1:0];
  endfunction

  logic signed [ANGLE_W-1:0] rot_d, tilt_d;
  logic                      within_d;

  logic                      valid_q;
  logic signed [ANGLE_W-1:0] rot_q, tilt_q;
  logic                      within_q, zero_q;

  always_comb begin
    rot_d    = flags_i.xz_zero ? '0 : round_sat(acc_rot_i);
    tilt_d   = flags_i.zero ? '0 : -round_sat(acc_tilt_i);
    within_d = (mag(tilt_d) <= tilt_limit_i) && (mag(rot_d) <= rotate_limit_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rot_q    <= rot_d;
      tilt_q   <= tilt_d;
      within_q <= within_d || flags_i.zero;
      zero_q   <= flags_i.zero;
    end
  end

  assign valid_o         = valid_q;
  assign tilt_angle_o    = tilt_q;
  assign rotate_angle_o  = rot_q;
  assign within_limits_o = within_q;
  assign zero_axis_o     = zero_q;

endmodule

@@ hw/rtl/spindle_tilt_rotate_angles.sv @@
// ----------------------------------------------------------------------------
// spindle_tilt_rotate_angles
// Axis direction to rotate (B) and tilt (A) angles by two CORDIC passes.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: axis_x/y/z, signed components of any common scale.
//   Output beat: tilt_angle = -atan2(y, |(x,z)|), rotate_angle = atan2(x, z),
//   both signed degrees * 256, plus within_limits and zero_axis.
//   Both channels use valid/stall; a beat moves when valid is high and
//   stall is low.
//   Pipeline: entry stage, one register per CORDIC iteration in each pass,
//   output stage. Throughput: one beat per cycle unless the output stalls;
//   every iteration has its own adder stage.
//   The whole pipe advances together; when the output holds a beat and the
//   receiver stalls, in_stall_o is raised and every stage keeps its contents.
//   Reset clears all valid bits and loads the limit registers with 120 and
//   90 degrees. The user writes limits (cfg_we_i/cfg_index_i/cfg_data_i)
//   only while the pipe is empty; the block does not enforce it.
// ----------------------------------------------------------------------------
module spindle_tilt_rotate_angles import stra_pkg::*; #(
  parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
  parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [COMPONENT_WIDTH-1:0] axis_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0] axis_y_i,
  input  logic signed [COMPONENT_WIDTH-1:0] axis_z_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [ANGLE_W-1:0]         tilt_angle_o,
  output logic signed [ANGLE_W-1:0]         rotate_angle_o,
  output logic                              within_limits_o,
  output logic                              zero_axis_o,
  input  logic                              cfg_we_i,
  input  logic [CFG_IDX_W-1:0]              cfg_index_i,
  input  logic [LIMIT_W-1:0]                cfg_data_i
);

  localparam int DW      = COMPONENT_WIDTH + GUARD_BITS + HEADROOM;
  localparam int NSTEPS  = (CORDIC_STEPS > ATAN_TABLE_LEN) ? ATAN_TABLE_LEN : CORDIC_STEPS;
  localparam int FLAGS_W = $bits(axis_flags_t);
  localparam int SIDE1_W = DW + FLAGS_W;
  localparam int SIDE2_W = ANGLE_ACC_W + FLAGS_W;

  logic adv;

  logic [LIMIT_W-1:0] tilt_limit_q, rotate_limit_q;

  // Pass one (z, x) and pass two (magnitude, K*y) chains
  logic                          p1_valid [NSTEPS+1];
  logic signed [DW-1:0]          p1_re    [NSTEPS+1];
  logic signed [DW-1:0]          p1_im    [NSTEPS+1];
  logic signed [ANGLE_ACC_W-1:0] p1_acc   [NSTEPS+1];
  logic [SIDE1_W-1:0]            p1_side  [NSTEPS+1];

  logic                          p2_valid [NSTEPS+1];
  logic signed [DW-1:0]          p2_re    [NSTEPS+1];
  logic signed [DW-1:0]          p2_im    [NSTEPS+1];
  logic signed [ANGLE_ACC_W-1:0] p2_acc   [NSTEPS+1];
  logic [SIDE2_W-1:0]            p2_side  [NSTEPS+1];

  logic signed [DW-1:0]          prep_y_im;
  axis_flags_t                   prep_flags;
  logic signed [DW-1:0]          mid_y_im;
  axis_flags_t                   mid_flags;
  logic signed [ANGLE_ACC_W-1:0] end_acc_rot;
  axis_flags_t                   end_flags;

  // Whole pipe moves unless a finished beat is held at the output
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tilt_limit_q   <= TILT_LIMIT_RST;
      rotate_limit_q <= ROTATE_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TILT_LIMIT:   tilt_limit_q   <= cfg_data_i;
        CFG_ROTATE_LIMIT: rotate_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  stra_prep #(
    .COMPONENT_WIDTH (COMPONENT_WIDTH),
    .DATA_W          (DW)
  ) u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (in_valid_i),
    .axis_x_i (axis_x_i),
    .axis_y_i (axis_y_i),
    .axis_z_i (axis_z_i),
    .valid_o  (p1_valid[0]),
    .re_o     (p1_re[0]),
    .im_o     (p1_im[0]),
    .acc_o    (p1_acc[0]),
    .y_im_o   (prep_y_im),
    .flags_o  (prep_flags)
  );

  assign p1_side[0] = {prep_y_im, prep_flags};

  for (genvar k = 0; k < NSTEPS; k++) begin : g_pass1
    stra_cordic_step #(
      .DATA_W (DW),
      .SIDE_W (SIDE1_W),
      .STEP   (k)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (p1_valid[k]),
      .re_i    (p1_re[k]),
      .im_i    (p1_im[k]),
      .acc_i   (p1_acc[k]),
      .side_i  (p1_side[k]),
      .valid_o (p1_valid[k+1]),
      .re_o    (p1_re[k+1]),
      .im_o    (p1_im[k+1]),
      .acc_o   (p1_acc[k+1]),
      .side_o  (p1_side[k+1])
    );
  end

  // Magnitude of pass one feeds pass two; its angle rides along as side data
  assign {mid_y_im, mid_flags} = p1_side[NSTEPS];
  assign p2_valid[0] = p1_valid[NSTEPS];
  assign p2_re[0]    = p1_re[NSTEPS];
  assign p2_im[0]    = mid_y_im;
  assign p2_acc[0]   = '0;
  assign p2_side[0]  = {p1_acc[NSTEPS], mid_flags};

  for (genvar k = 0; k < NSTEPS; k++) begin : g_pass2
    stra_cordic_step #(
      .DATA_W (DW),
      .SIDE_W (SIDE2_W),
      .STEP   (k)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (p2_valid[k]),
      .re_i    (p2_re[k]),
      .im_i    (p2_im[k]),
      .acc_i   (p2_acc[k]),
      .side_i  (p2_side[k]),
      .valid_o (p2_valid[k+1]),
      .re_o    (p2_re[k+1]),
      .im_o    (p2_im[k+1]),
      .acc_o   (p2_acc[k+1]),
      .side_o  (p2_side[k+1])
    );
  end

  assign {end_acc_rot, end_flags} = p2_side[NSTEPS];

  stra_finish u_finish (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .valid_i         (p2_valid[NSTEPS]),
    .acc_rot_i       (end_acc_rot),
    .acc_tilt_i      (p2_acc[NSTEPS]),
    .flags_i         (end_flags),
    .tilt_limit_i    (tilt_limit_q),
    .rotate_limit_i  (rotate_limit_q),
    .valid_o         (out_valid_o),
    .tilt_angle_o    (tilt_angle_o),
    .rotate_angle_o  (rotate_angle_o),
    .within_limits_o (within_limits_o),
    .zero_axis_o     (zero_axis_o)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_zero_axis_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && zero_axis_o) |->
      (tilt_angle_o == '0 && rotate_angle_o == '0 && within_limits_o))
    else $error("zero axis beat with non-zero angles or out of limits");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (rotate_angle_o <= ANGLE_MAX && rotate_angle_o >= -ANGLE_MAX &&
       tilt_angle_o <= ANGLE_MAX && tilt_angle_o >= -ANGLE_MAX))
    else $error("angle beyond +-180 degrees");

  a_rotate_within: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && within_limits_o) |->
      ($signed({2'b00, rotate_limit_q}) >= (ANGLE_W+1)'(rotate_angle_o) &&
       -$signed({2'b00, rotate_limit_q}) <= (ANGLE_W+1)'(rotate_angle_o)))
    else $error("within_limits set with rotation beyond its limit");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(rotate_angle_o) &&
      $stable(tilt_angle_o)))
    else $error("held output beat lost or changed");

endmodule
